[sv/vpcw_pkg.sv]
`default_nettype none

package vpcw_pkg;

  // Configuration space geometry.
  localparam int CONFIG_DWORDS = 64;
  localparam int WORD_IDX_W    = 6;

  // Capability list constants.
  localparam logic [7:0] CAP_PTR_OFFSET = 8'h34;
  localparam logic [7:0] CAP_PTR_END    = 8'hFF;
  localparam logic [7:0] CAP_ID_VENDOR  = 8'h09;
  localparam logic [7:0] CFG_COMMON     = 8'h01;
  localparam logic [7:0] CFG_NOTIFY     = 8'h02;
  localparam logic [7:0] CFG_ISR        = 8'h03;
  localparam logic [7:0] CFG_DEVICE     = 8'h04;
  localparam logic [7:0] BAR0_OFFSET    = 8'h10;
  localparam logic [7:0] DWORD_STEP     = 8'h04;
  localparam logic [31:0] BAR_FLAG_MASK = 32'h0000_000F;
  localparam logic [1:0] BAR_TYPE_64    = 2'b10;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_WALK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PTR,
    ST_CHECK,
    ST_HDR,
    ST_BAR,
    ST_OFFS,
    ST_LEN,
    ST_LO,
    ST_HI,
    ST_MULT,
    ST_REC,
    ST_DONE
  } vpcw_state_t;

  // Byte offset that a config read is taken from.
  typedef enum logic [2:0] {
    SEL_PTR,
    SEL_CAP,
    SEL_CAP4,
    SEL_CAP8,
    SEL_CAP12,
    SEL_CAP16,
    SEL_BAR,
    SEL_BAR4
  } vpcw_addr_sel_t;

  typedef struct packed {
    logic           mem_wr;
    logic           rd_en;
    vpcw_addr_sel_t rd_sel;
    logic           clr_acc;
    logic           ld_ptr;
    logic           ld_hdr;
    logic           adv_cap;
    logic           ld_bar;
    logic           ld_offs;
    logic           ld_len;
    logic           ld_lo;
    logic           ld_hi;
    logic           ld_mult;
    logic           rec;
    logic           out_load;
  } vpcw_cmd_t;

  typedef struct packed {
    logic cap_end;
    logic vendor;
    logic bar64;
    logic notify;
    logic out_free;
  } vpcw_status_t;

endpackage

`default_nettype wire

[sv/vpcw_if.sv]
`default_nettype none

// Input channel: one load or walk item.
interface vpcw_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  word_index;
  logic [31:0] word_data;

  modport source (output valid, kind, word_index, word_data, input ready);
  modport sink (input valid, kind, word_index, word_data, output ready);
endinterface

// Output channel: one walk report item.
interface vpcw_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] common_addr;
  logic [31:0] common_size;
  logic [63:0] notify_addr;
  logic [31:0] notify_size;
  logic [31:0] notify_scale;
  logic [63:0] isr_addr;
  logic [31:0] isr_len;
  logic [63:0] device_addr;
  logic [31:0] device_size;
  logic        status;

  modport source (output valid, common_addr, common_size, notify_addr, notify_size,
                  notify_scale, isr_addr, isr_len, device_addr, device_size, status,
                  input ready);
  modport sink (input valid, common_addr, common_size, notify_addr, notify_size,
                notify_scale, isr_addr, isr_len, device_addr, device_size, status,
                output ready);
endinterface

`default_nettype wire

[sv/vpcw_ram.sv]
`default_nettype none

module vpcw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/vpcw_ctrl.sv]
`default_nettype none

module vpcw_ctrl
  import vpcw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         in_kind,
  output      logic         in_ready,
  input  wire vpcw_status_t stat,
  output      vpcw_cmd_t    cmd
);

  vpcw_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_kind == KIND_WALK) state_next = ST_PTR;
      end
      ST_PTR:   state_next = ST_CHECK;
      ST_CHECK: state_next = stat.cap_end ? ST_DONE : ST_HDR;
      ST_HDR:   state_next = stat.vendor ? ST_BAR : ST_CHECK;
      ST_BAR:   state_next = ST_OFFS;
      ST_OFFS:  state_next = ST_LEN;
      ST_LEN:   state_next = ST_LO;
      ST_LO: begin
        if (stat.bar64) state_next = ST_HI;
        else if (stat.notify) state_next = ST_MULT;
        else state_next = ST_REC;
      end
      ST_HI:    state_next = stat.notify ? ST_MULT : ST_REC;
      ST_MULT:  state_next = ST_REC;
      ST_REC:   state_next = ST_CHECK;
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    cmd.rd_sel = SEL_PTR;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_kind == KIND_LOAD) begin
          cmd.mem_wr = 1'b1;
        end else if (in_valid) begin
          cmd.clr_acc = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = SEL_PTR;
        end
      end
      ST_PTR: cmd.ld_ptr = 1'b1;
      ST_CHECK: begin
        cmd.rd_en  = !stat.cap_end;
        cmd.rd_sel = SEL_CAP;
      end
      ST_HDR: begin
        cmd.ld_hdr  = 1'b1;
        cmd.adv_cap = !stat.vendor;
        cmd.rd_en   = stat.vendor;
        cmd.rd_sel  = SEL_CAP4;
      end
      ST_BAR: begin
        cmd.ld_bar = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_CAP8;
      end
      ST_OFFS: begin
        cmd.ld_offs = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_CAP12;
      end
      ST_LEN: begin
        cmd.ld_len = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_BAR;
      end
      ST_LO: begin
        cmd.ld_lo  = 1'b1;
        cmd.rd_en  = stat.bar64 || stat.notify;
        cmd.rd_sel = stat.bar64 ? SEL_BAR4 : SEL_CAP16;
      end
      ST_HI: begin
        cmd.ld_hi  = 1'b1;
        cmd.rd_en  = stat.notify;
        cmd.rd_sel = SEL_CAP16;
      end
      ST_MULT: cmd.ld_mult = 1'b1;
      ST_REC: begin
        cmd.rec     = 1'b1;
        cmd.adv_cap = 1'b1;
      end
      ST_DONE: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/vpcw_dpath.sv]
`default_nettype none

module vpcw_dpath
  import vpcw_pkg::*;
#(
  parameter int MAX_CAPS = 48
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire vpcw_cmd_t         cmd,
  output      vpcw_status_t      stat,
  input  wire logic [WORD_IDX_W-1:0] word_index,
  input  wire logic [31:0]       word_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [63:0]       out_common_addr,
  output      logic [31:0]       out_common_size,
  output      logic [63:0]       out_notify_addr,
  output      logic [31:0]       out_notify_size,
  output      logic [31:0]       out_notify_scale,
  output      logic [63:0]       out_isr_addr,
  output      logic [31:0]       out_isr_len,
  output      logic [63:0]       out_device_addr,
  output      logic [31:0]       out_device_size,
  output      logic              out_status
);

  localparam int VisW = $clog2(MAX_CAPS + 1);

  logic [CONFIG_DWORDS-1:0] valid;
  logic                     valid_q;
  logic [31:0]              ram_q;
  logic [31:0]              rdat;
  logic [7:0]               rd_byte;
  logic [WORD_IDX_W-1:0]    rd_idx;

  logic [7:0]      cap;
  logic [7:0]      nxt;
  logic [7:0]      ctype;
  logic [VisW-1:0] visited;
  logic [7:0]      bar_off;
  logic [31:0]     offs;
  logic [31:0]     len;
  logic [63:0]     base;
  logic [31:0]     mult;
  logic [63:0]     pa;

  logic [63:0] common_addr, notify_addr, isr_addr, device_addr;
  logic [31:0] common_size, notify_size, notify_scale, isr_len, device_size;

  // Byte offset of the dword being read; it wraps at 256 bytes.
  always_comb begin
    unique case (cmd.rd_sel)
      SEL_PTR:   rd_byte = CAP_PTR_OFFSET;
      SEL_CAP:   rd_byte = cap;
      SEL_CAP4:  rd_byte = cap + DWORD_STEP;
      SEL_CAP8:  rd_byte = cap + 8'd8;
      SEL_CAP12: rd_byte = cap + 8'd12;
      SEL_CAP16: rd_byte = cap + 8'd16;
      SEL_BAR:   rd_byte = bar_off;
      SEL_BAR4:  rd_byte = bar_off + DWORD_STEP;
      default:   rd_byte = cap;
    endcase
  end

  assign rd_idx = rd_byte[7:2];

  vpcw_ram #(
    .WIDTH(32),
    .DEPTH(CONFIG_DWORDS)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (cmd.mem_wr),
    .waddr (word_index),
    .wdata (word_data),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  // Per-dword written flags; an unwritten dword reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cmd.mem_wr) valid[word_index] <= 1'b1;
      if (cmd.rd_en) valid_q <= valid[rd_idx];
    end
  end

  assign rdat = valid_q ? ram_q : 32'h0;

  // Status back to the controller.
  assign stat.cap_end  = (cap == 8'h00) || (cap == CAP_PTR_END) ||
                         (visited == VisW'(MAX_CAPS));
  assign stat.vendor   = (rdat[7:0] == CAP_ID_VENDOR);
  assign stat.bar64    = (rdat[2:1] == BAR_TYPE_64);
  assign stat.notify   = (ctype == CFG_NOTIFY);
  assign stat.out_free = !out_valid || out_ready;

  // Walk registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_ptr) begin
      cap     <= rdat[7:0];
      visited <= '0;
    end
    if (cmd.ld_hdr) begin
      nxt     <= rdat[15:8];
      ctype   <= rdat[31:24];
      visited <= visited + VisW'(1);
    end
    if (cmd.ld_hdr && cmd.adv_cap) cap <= rdat[15:8];
    if (cmd.rec && cmd.adv_cap) cap <= nxt;
    if (cmd.ld_bar) bar_off <= BAR0_OFFSET + {rdat[5:0], 2'b00};
    if (cmd.ld_offs) offs <= rdat;
    if (cmd.ld_len) len <= rdat;
    if (cmd.ld_lo) base <= {32'h0, rdat & ~BAR_FLAG_MASK};
    if (cmd.ld_hi) base[63:32] <= rdat;
    if (cmd.ld_mult) mult <= rdat;
  end

  assign pa = base + {32'h0, offs};

  // Region records; a later capability of the same type overwrites.
  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      common_addr  <= '0;
      common_size  <= '0;
      notify_addr  <= '0;
      notify_size  <= '0;
      notify_scale <= '0;
      isr_addr     <= '0;
      isr_len      <= '0;
      device_addr  <= '0;
      device_size  <= '0;
    end else if (cmd.rec) begin
      if (ctype == CFG_COMMON) begin
        common_addr <= pa;
        common_size <= len;
      end
      if (ctype == CFG_NOTIFY) begin
        notify_addr  <= pa;
        notify_size  <= len;
        notify_scale <= mult;
      end
      if (ctype == CFG_ISR) begin
        isr_addr <= pa;
        isr_len  <= len;
      end
      if (ctype == CFG_DEVICE) begin
        device_addr <= pa;
        device_size <= len;
      end
    end
  end

  // Output register; holds the report until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_common_addr  <= common_addr;
      out_common_size  <= common_size;
      out_notify_addr  <= notify_addr;
      out_notify_size  <= notify_size;
      out_notify_scale <= notify_scale;
      out_isr_addr     <= isr_addr;
      out_isr_len      <= isr_len;
      out_device_addr  <= device_addr;
      out_device_size  <= device_size;
      out_status       <= (common_addr == 64'h0);
    end
  end

  // The visit count never passes the limit.
  a_visit_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_hdr |-> visited < VisW'(MAX_CAPS))
    else $error("capability visit count passed its limit");

  // A report is loaded only into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("report loaded over a pending report");

  // A loaded report is presented in the next cycle.
  a_out_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded report not presented");

  // The config store is never written during a walk read.
  a_no_wr_rd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_wr && cmd.rd_en))
    else $error("config write collided with a walk read");

endmodule

`default_nettype wire

[sv/virtio_pci_capability_walker.sv]
// Load item: one load per cycle while no walk is running, no report.
// Walk item: reads the capability pointer, then the header of each capability;
// a vendor capability also reads its BAR, offset, length and BAR base (one more
// read each for a 64-bit BAR and for a notify entry). The report waits while an
// earlier report is still held; each field takes one registered config RAM read.
// One walk runs at a time. Reset clears the written flags, so config space
// reads as all zero at once; no clearing pass is needed.
`default_nettype none

module virtio_pci_capability_walker
  import vpcw_pkg::*;
#(
  parameter int MAX_CAPS = 48
) (
  input wire logic clk,
  input wire logic rst,
  vpcw_in_if.sink    cmd,
  vpcw_out_if.source rpt
);

  vpcw_cmd_t    dp_cmd;
  vpcw_status_t dp_stat;
  logic         in_ready;

  assign cmd.ready = in_ready;

  vpcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_kind  (cmd.kind),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  vpcw_dpath #(
    .MAX_CAPS(MAX_CAPS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (dp_cmd),
    .stat             (dp_stat),
    .word_index       (cmd.word_index),
    .word_data        (cmd.word_data),
    .out_valid        (rpt.valid),
    .out_ready        (rpt.ready),
    .out_common_addr  (rpt.common_addr),
    .out_common_size  (rpt.common_size),
    .out_notify_addr  (rpt.notify_addr),
    .out_notify_size  (rpt.notify_size),
    .out_notify_scale (rpt.notify_scale),
    .out_isr_addr     (rpt.isr_addr),
    .out_isr_len      (rpt.isr_len),
    .out_device_addr  (rpt.device_addr),
    .out_device_size  (rpt.device_size),
    .out_status       (rpt.status)
  );

endmodule

`default_nettype wire
